// ----- rtl/core/ach_pkg.sv -----
// Package for the aging callsign hash table: field widths, codes, payload structs,
// controller states and the command and status groups between controller and datapath.
// No dependencies.
package ach_pkg;

  // Field widths of the transaction payloads and the slot store
  localparam int unsigned NAME_HEAD_W = 64;
  localparam int unsigned NAME_TAIL_W = 24;
  localparam int unsigned NAME_W      = NAME_HEAD_W + NAME_TAIL_W;
  localparam int unsigned HASH_W      = 22;
  localparam int unsigned AGE_W       = 8;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned HOME_KEY_W  = 10;
  localparam int unsigned HOME_PROD_W = 15;   // 10-bit key times 23 fits in 15 bits
  localparam int unsigned HOME_MUL    = 23;

  // Configuration port
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_MAX_AGE = 1'b0;   // word index of max_age
  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd60;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SWEEP  = 2'd2
  } op_e;

  // Lookup hash widths
  typedef enum logic [1:0] {
    KIND_H22 = 2'd0,
    KIND_H12 = 2'd1,
    KIND_H10 = 2'd2
  } hash_kind_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]             op;
    logic [NAME_HEAD_W-1:0] name_head;
    logic [NAME_TAIL_W-1:0] name_tail;
    logic [HASH_W-1:0]      hash_value;
    logic [1:0]             hash_kind;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic                   found;
    logic [NAME_HEAD_W-1:0] found_head;
    logic [NAME_TAIL_W-1:0] found_tail;
    logic [COUNT_W-1:0]     occupied_count;
  } rsp_t;

  // One slot of the table
  typedef struct packed {
    logic [NAME_HEAD_W-1:0] head;
    logic [NAME_TAIL_W-1:0] tail;
    logic [HASH_W-1:0]      hash;
    logic [AGE_W-1:0]       age;
  } slot_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME1,
    ST_HOME2,
    ST_ISSUE,
    ST_PROBE,
    ST_SWP_RD,
    ST_SWP_WR,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted transaction
    logic issue;      // read the home slot, restart the probe count
    logic probe_rd;   // read the slot after the current one
    logic advance;    // step to the next probe slot
    logic add_wr;     // write the new entry
    logic add_full;   // ... at the home slot after a full wrap
    logic add_new;    // ... into an empty slot
    logic hit;        // capture the found name
    logic idx_rst;    // slot index back to zero
    logic sweep_wr;   // age or free the current slot
    logic clear_wr;   // zero the current slot
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_name_empty;  // offered name starts with a zero byte
    logic slot_busy;      // slot just read is occupied
    logic add_match;      // slot just read holds the same name and hash
    logic lkp_match;      // slot just read matches the lookup hash
    logic probe_last;     // whole table probed
    logic idx_last;       // index on the last slot
  } sts_t;

endpackage

// ----- rtl/core/aging_callsign_hash_table_core.sv -----
// Aging callsign hash table: open-addressed slots with linear probing and per-entry age.
// Sequence: an add or lookup passes ST_HOME1, ST_HOME2 and ST_ISSUE, then probes slots in ST_PROBE;
// an add of an empty name or an unused op goes straight to ST_DONE; a sweep reads each slot in turn.
// A new transaction is taken only while busy is low; one slot memory port paces probe and sweep.
// Reset: a clearing pass zeroes every slot with busy high;
// done_o is a one-cycle strobe and the receiver cannot stall it.
module aging_callsign_hash_table_core #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command channel
  input  logic                              start,
  output logic                              busy,
  input  ach_pkg::req_t                     req_i,
  // Result channel
  output logic                              done_o,
  output ach_pkg::rsp_t                     rsp_o,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ach_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ach_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ach_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ach_pkg::*;

  ach_pkg::cmd_t          cmd;
  ach_pkg::sts_t          sts;
  logic [AGE_W-1:0]       max_age_q;
  logic                   reg_sel;

  // Configuration register: word index from the upper address bit
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MAX_AGE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_age_q <= pwdata[AGE_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(max_age_q) : '0;

  // Controller
  ach_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Datapath
  ach_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .max_age_i (max_age_q),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .rsp_o     (rsp_o)
  );

endmodule

// ----- rtl/core/ach_ctrl.sv -----
// Controller of the aging callsign hash table: sequences the clearing pass,
// home slot computation, linear probe and age sweep. Uses ach_pkg.
module ach_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    op_i,
  input  ach_pkg::sts_t sts_i,
  output ach_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import ach_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] op_q, op_d;

  // State and operation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q    <= OP_ADD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.idx_last) state_d = ST_IDLE;
      end
      ST_IDLE, ST_DONE: begin
        busy_o  = 1'b0;
        done_o  = (state_q == ST_DONE);
        state_d = ST_IDLE;
        if (start_i) begin
          cmd_o.load = 1'b1;
          op_d       = op_i;
          case (op_i)
            OP_ADD:    state_d = sts_i.in_name_empty ? ST_DONE : ST_HOME1;
            OP_LOOKUP: state_d = ST_HOME1;
            OP_SWEEP: begin
              cmd_o.idx_rst = 1'b1;
              state_d       = ST_SWP_RD;
            end
            default:   state_d = ST_DONE;   // unused code: no operation
          endcase
        end
      end
      ST_HOME1: state_d = ST_HOME2;
      ST_HOME2: state_d = ST_ISSUE;
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_PROBE;
      end
      ST_PROBE: begin
        cmd_o.probe_rd = 1'b1;
        if (!sts_i.slot_busy) begin
          // end of chain: add fills this slot, lookup misses
          if (op_q == OP_ADD) begin
            cmd_o.add_wr  = 1'b1;
            cmd_o.add_new = 1'b1;
          end
          state_d = ST_DONE;
        end else if (op_q == OP_ADD && sts_i.add_match) begin
          // same entry: refresh its age
          cmd_o.add_wr = 1'b1;
          state_d      = ST_DONE;
        end else if (op_q == OP_LOOKUP && sts_i.lkp_match) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_DONE;
        end else if (sts_i.probe_last) begin
          // full wrap: add overwrites the home slot
          if (op_q == OP_ADD) begin
            cmd_o.add_wr   = 1'b1;
            cmd_o.add_full = 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_SWP_RD: state_d = ST_SWP_WR;
      ST_SWP_WR: begin
        cmd_o.sweep_wr = 1'b1;
        state_d        = sts_i.idx_last ? ST_DONE : ST_SWP_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ach_dp.sv -----
// Datapath of the aging callsign hash table: slot memory, home slot arithmetic,
// probe index, match compares, occupancy count and result registers. Uses ach_pkg.
module ach_dp #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ach_pkg::req_t               req_i,
  input  logic [ach_pkg::AGE_W-1:0]   max_age_i,
  input  ach_pkg::cmd_t               cmd_i,
  output ach_pkg::sts_t               sts_o,
  output ach_pkg::rsp_t               rsp_o
);
  import ach_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned PROD_W = HOME_PROD_W + 33;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
  // floor(2^32 / slots): quotient estimate is exact or one low for 15-bit values
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TABLE_SLOTS);

  // Zero every byte after the first zero byte of the 11-byte name
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_HEAD_W-1:0] head,
                                                   input logic [NAME_TAIL_W-1:0] tail);
    logic [NAME_W-1:0] nm;
    logic              ended;
    nm    = {head, tail};
    ended = 1'b0;
    for (int i = NAME_W / 8 - 1; i >= 0; i--) begin
      if (nm[i*8 +: 8] == 8'h00) ended = 1'b1;
      if (ended) nm[i*8 +: 8] = 8'h00;
    end
    return nm;
  endfunction

  // Captured transaction
  logic [NAME_HEAD_W-1:0] head_q;
  logic [NAME_TAIL_W-1:0] tail_q;
  logic [HASH_W-1:0]      hash_q;
  logic [1:0]             kind_q;
  logic [NAME_W-1:0]      name_n;
  logic [HOME_KEY_W-1:0]  key;

  // Home slot arithmetic
  logic [HOME_PROD_W-1:0] prod_q;
  logic [HOME_PROD_W-1:0] quot_q;
  logic [PROD_W-1:0]      recip_prod;
  logic [31:0]            rem_raw;
  logic [31:0]            rem_fix;
  logic [IDX_W-1:0]       home_q;

  // Probe and sweep index
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] cur_inc;
  logic [IDX_W-1:0] probe_q, probe_d;
  logic [CNT_W-1:0] used_q, used_d;

  // Slot memory
  slot_t            mem_q [TABLE_SLOTS];
  slot_t            rd_q;
  slot_t            wdata;
  logic             we;
  logic [IDX_W-1:0] addr;

  // Compares on the slot just read
  logic [HASH_W-1:0] rd_hash_sh;
  logic              expire;

  // Result registers
  logic                   found_q;
  logic [NAME_HEAD_W-1:0] found_head_q;
  logic [NAME_TAIL_W-1:0] found_tail_q;

  // Name form and hash key of the offered transaction
  assign name_n = norm_name(req_i.name_head, req_i.name_tail);

  always_comb begin
    key = req_i.hash_value[HASH_W-1 -: HOME_KEY_W];
    if (req_i.op == OP_LOOKUP) begin
      case (req_i.hash_kind)
        KIND_H12: key = req_i.hash_value[HOME_KEY_W+1:2];
        KIND_H10: key = req_i.hash_value[HOME_KEY_W-1:0];
        default:  key = req_i.hash_value[HASH_W-1 -: HOME_KEY_W];
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      head_q <= name_n[NAME_W-1 -: NAME_HEAD_W];
      tail_q <= name_n[NAME_TAIL_W-1:0];
      hash_q <= req_i.hash_value;
      kind_q <= req_i.hash_kind;
      prod_q <= HOME_PROD_W'(key) * HOME_PROD_W'(HOME_MUL);
    end
  end

  // Home slot: product mod slots by reciprocal, two register stages
  assign recip_prod = PROD_W'(prod_q) * PROD_W'(RECIP);
  assign rem_raw    = 32'(prod_q) - 32'(quot_q) * 32'(TABLE_SLOTS);
  assign rem_fix    = (rem_raw >= 32'(TABLE_SLOTS)) ? rem_raw - 32'(TABLE_SLOTS) : rem_raw;

  always_ff @(posedge clk_i) begin
    quot_q <= recip_prod[32 +: HOME_PROD_W];
    home_q <= rem_fix[IDX_W-1:0];
  end

  // Index stepping with wrap
  assign cur_inc = (cur_q == IDX_LAST) ? '0 : cur_q + 1'b1;

  always_comb begin
    cur_d   = cur_q;
    probe_d = probe_q;
    if (cmd_i.idx_rst) cur_d = '0;
    if (cmd_i.issue) begin
      cur_d   = home_q;
      probe_d = '0;
    end
    if (cmd_i.advance) begin
      cur_d   = cur_inc;
      probe_d = probe_q + 1'b1;
    end
    if (cmd_i.sweep_wr || cmd_i.clear_wr) cur_d = cur_inc;
  end

  // Slot compares
  always_comb begin
    case (kind_q)
      KIND_H12: rd_hash_sh = rd_q.hash >> 10;
      KIND_H10: rd_hash_sh = rd_q.hash >> 12;
      default:  rd_hash_sh = rd_q.hash;
    endcase
  end

  assign expire = (rd_q.age >= max_age_i);

  assign sts_o.in_name_empty = (req_i.name_head[NAME_HEAD_W-1 -: 8] == 8'h00);
  assign sts_o.slot_busy     = (rd_q.head[NAME_HEAD_W-1 -: 8] != 8'h00);
  assign sts_o.add_match     = (rd_q.hash == hash_q) && (rd_q.head == head_q)
                               && (rd_q.tail == tail_q);
  assign sts_o.lkp_match     = (rd_hash_sh == hash_q);
  assign sts_o.probe_last    = (probe_q == IDX_LAST);
  assign sts_o.idx_last      = (cur_q == IDX_LAST);

  // Memory port: one write or one read a cycle
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    addr  = cur_q;
    if (cmd_i.issue) addr = home_q;
    else if (cmd_i.probe_rd) addr = cur_inc;
    if (cmd_i.add_wr) begin
      we         = 1'b1;
      addr       = cmd_i.add_full ? home_q : cur_q;
      wdata.head = head_q;
      wdata.tail = tail_q;
      wdata.hash = hash_q;
      wdata.age  = '0;
    end else if (cmd_i.sweep_wr) begin
      we   = sts_o.slot_busy;
      addr = cur_q;
      if (!expire) begin
        wdata     = rd_q;
        wdata.age = rd_q.age + 1'b1;
      end
    end else if (cmd_i.clear_wr) begin
      we   = 1'b1;
      addr = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end else begin
      rd_q <= mem_q[addr];
    end
  end

  // Occupancy count
  always_comb begin
    used_d = used_q;
    if (cmd_i.add_wr && cmd_i.add_new) used_d = CNT_W'(used_q + 1'b1);
    if (cmd_i.sweep_wr && sts_o.slot_busy && expire) used_d = CNT_W'(used_q - 1'b1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      probe_q <= '0;
      used_q  <= '0;
      found_q <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      probe_q <= probe_d;
      used_q  <= used_d;
      if (cmd_i.load) found_q <= 1'b0;
      else if (cmd_i.hit) found_q <= 1'b1;
    end
  end

  // Found name, zero unless a lookup hit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      found_head_q <= '0;
      found_tail_q <= '0;
    end else if (cmd_i.hit) begin
      found_head_q <= rd_q.head;
      found_tail_q <= rd_q.tail;
    end
  end

  assign rsp_o.found          = found_q;
  assign rsp_o.found_head     = found_head_q;
  assign rsp_o.found_tail     = found_tail_q;
  assign rsp_o.occupied_count = COUNT_W'(used_q);

endmodule
